// ===== design/barrett_modular_exponentiation_macros.svh =====
// Assertion helpers for the modular exponentiation block.
`ifndef BARRETT_MODULAR_EXPONENTIATION_MACROS_SVH
`define BARRETT_MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define BME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define BME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BME_ASSERT_IMP(lbl, ante, cons, msg)
`define BME_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/bme_pkg.sv =====
package bme_pkg;

  localparam int LIMBS   = 64;
  localparam int LW      = 32;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 40;
  localparam int OP_W    = 3;
  localparam int IDX_W   = 7;
  localparam int RIDX_W  = 6;
  localparam int CW      = $clog2(2 * LIMBS + 3);
  localparam int BW      = $clog2(LIMBS * LW);

  localparam logic [CW-1:0] K_L   = CW'(LIMBS);
  localparam logic [CW-1:0] K_LM1 = CW'(LIMBS - 1);
  localparam logic [CW-1:0] K_L1  = CW'(LIMBS + 1);
  localparam logic [CW-1:0] K_2L  = CW'(2 * LIMBS);
  localparam logic [CW-1:0] K_2L2 = CW'(2 * LIMBS + 2);
  localparam logic [BW-1:0] BIT_TOP = BW'(LIMBS * LW - 1);

  localparam logic [OP_W-1:0] OP_LOAD_BASE = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_EXP  = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_MOD  = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD_MU   = 3'd3;
  localparam logic [OP_W-1:0] OP_COMPUTE   = 3'd4;

  typedef enum logic {
    ALU_MAC = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e         op;
    logic [LW-1:0]   a;
    logic [LW-1:0]   b;
    logic [LW-1:0]   c;
    logic [LW-1:0]   cin;
  } alu_req_t;

  typedef struct packed {
    logic [LW-1:0] lo;
    logic [LW-1:0] hi;
  } alu_rsp_t;

endpackage

// ===== design/bme_ram.sv =====
module bme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/bme_alu.sv =====
module bme_alu import bme_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [2*LW-1:0] mul;
  logic [2*LW-1:0] sum;
  logic [LW:0]     diff;

  // one limb product plus the partial sum and the running carry; fits in two limbs
  assign mul  = {{LW{1'b0}}, req_i.a} * {{LW{1'b0}}, req_i.b};
  assign sum  = mul + {{LW{1'b0}}, req_i.c} + {{LW{1'b0}}, req_i.cin};
  assign diff = {1'b0, req_i.a} - {1'b0, req_i.b} - {{LW{1'b0}}, req_i.cin[0]};

  always_comb begin
    case (req_i.op)
      ALU_MAC: begin
        rsp_o.lo = sum[LW-1:0];
        rsp_o.hi = sum[2*LW-1:LW];
      end
      ALU_SUB: begin
        rsp_o.lo = diff[LW-1:0];
        rsp_o.hi = {{(LW-1){1'b0}}, diff[LW]};
      end
      default: begin
        rsp_o.lo = '0;
        rsp_o.hi = '0;
      end
    endcase
  end

endmodule

// ===== design/barrett_modular_exponentiation.sv =====
// Barrett modular exponentiation, limb-serial datapath.
// Input stream: tuser carries the op (load base, exponent, modulus, mu, or
// compute); tdata carries limb_index [6:0] and limb_value [38:7]. Load items
// are taken one per cycle; indexes beyond a store are dropped, as are unused ops.
// A compute item runs a left-to-right square-and-multiply over the exponent,
// skipping leading zeros. Every pass is a schoolbook product one 32x32 limb
// MAC at a time, then Barrett reduction (a top-by-mu product, a truncated back
// product, a wrapping subtract, up to three trial subtracts), all through on-chip RAMs.
// Steps: the accumulator is first set to one, then each exponent bit is read;
// each square or multiply runs the full, top-by-mu and truncated back
// products one MAC at a time, then the subtract, compare and copy sweeps one
// limb at a time, with up to three trial subtracts; the result is then emitted.
// There is a single MAC unit and one read port per RAM.
// Ready stays low from the compute item until the last result limb is handed
// to the output register. Results leave as LIMBS items, index first, with
// tlast on the top limb. A stalled receiver holds the output register and
// the emit sweep waits on it. Reset returns to idle with no output pending;
// operand stores keep no reset and must be loaded before a compute.
`include "barrett_modular_exponentiation_macros.svh"

module barrett_modular_exponentiation import bme_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [IN_DW-1:0]  s_axis_tdata_i,   // limb_index [6:0], limb_value [38:7]
  input  logic [OP_W-1:0]   s_axis_tuser_i,   // op [2:0]
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_DW-1:0] m_axis_tdata_o,   // result_index [5:0], result_limb [37:6]
  output logic              m_axis_tlast_o
);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_INIT   = 19'h00002,
    S_EXPRD  = 19'h00004,
    S_EXPBIT = 19'h00008,
    S_ROWA   = 19'h00010,
    S_ROWB   = 19'h00020,
    S_RD     = 19'h00040,
    S_MAC    = 19'h00080,
    S_CARRY  = 19'h00100,
    S_SUBRD  = 19'h00200,
    S_SUBWR  = 19'h00400,
    S_CMPRD  = 19'h00800,
    S_CMPCHK = 19'h01000,
    S_TSUBRD = 19'h02000,
    S_TSUBWR = 19'h04000,
    S_COPYRD = 19'h08000,
    S_COPYWR = 19'h10000,
    S_OUTRD  = 19'h20000,
    S_OUTLD  = 19'h40000
  } state_e;

  // which limb product is running: x*y into prod, top(x)*mu into quot,
  // top(q)*modulus into back
  typedef enum logic [1:0] {
    MUL_PROD = 2'd0,
    MUL_QUOT = 2'd1,
    MUL_BACK = 2'd2
  } mul_e;

  state_e          state_q, state_d;
  mul_e            mul_q, mul_d;
  logic [CW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic [BW-1:0]   bit_q, bit_d;
  logic [1:0]      trial_q, trial_d;
  logic [LW-1:0]   carry_q, carry_d, a_q, a_d;
  logic            borrow_q, borrow_d;
  logic            ebit_q, ebit_d, started_q, started_d, sq_q, sq_d;
  logic            out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [RIDX_W-1:0] out_idx_q, out_idx_d;
  logic [LW-1:0]   out_limb_q, out_limb_d;

  // RAM ports
  logic base_we, exp_we, mod_we, mu_we, acc_we, prod_we, quot_we, back_we, low_we;
  logic base_re, exp_re, mod_re, mu_re, acc_re, prod_re, quot_re, back_re, low_re;
  logic [CW-1:0] base_ra, exp_ra, mod_ra, mu_ra, acc_ra, prod_ra, quot_ra, back_ra, low_ra;
  logic [CW-1:0] acc_wa, res_wa, low_wa, load_idx;
  logic [LW-1:0] acc_wd, res_wd, low_wd, load_val;
  logic [LW-1:0] base_rd, exp_rd, mod_rd, mu_rd, acc_rd, prod_rd, quot_rd, back_rd, low_rd;
  logic          res_we, in_acc;
  logic [OP_W-1:0] in_op;

  // operand selection for the running product
  logic [CW-1:0] na, nb, nres, a_off, a_addr, r_addr, c_addr;
  logic [LW-1:0] a_rd, b_rd, r_rd, mod_w;
  logic          ebit_now;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  bme_alu u_alu (.req_i(alu_req), .rsp_o(alu_rsp));

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op    = s_axis_tuser_i;
  assign load_idx = CW'(s_axis_tdata_i[IDX_W-1:0]);
  assign load_val = s_axis_tdata_i[IDX_W+LW-1:IDX_W];
  assign s_axis_tready_o = (state_q == S_IDLE);

  assign base_we = in_acc && (in_op == OP_LOAD_BASE) && (load_idx < K_L);
  assign exp_we  = in_acc && (in_op == OP_LOAD_EXP)  && (load_idx < K_L);
  assign mod_we  = in_acc && (in_op == OP_LOAD_MOD)  && (load_idx < K_L);
  assign mu_we   = in_acc && (in_op == OP_LOAD_MU)   && (load_idx < K_L1);

  assign prod_we = res_we && (mul_q == MUL_PROD);
  assign quot_we = res_we && (mul_q == MUL_QUOT);
  assign back_we = res_we && (mul_q == MUL_BACK);

  always_comb begin
    case (mul_q)
      MUL_PROD: begin
        na = K_L;  nb = K_L;  nres = K_2L;  a_off = '0;
        a_rd = acc_rd;  b_rd = sq_q ? acc_rd : base_rd;  r_rd = prod_rd;
      end
      MUL_QUOT: begin
        na = K_L1; nb = K_L1; nres = K_2L2; a_off = K_LM1;
        a_rd = prod_rd; b_rd = mu_rd;  r_rd = quot_rd;
      end
      MUL_BACK: begin
        na = K_L1; nb = K_L;  nres = K_L1;  a_off = K_L1;
        a_rd = quot_rd; b_rd = mod_rd; r_rd = back_rd;
      end
      default: begin
        na = K_L;  nb = K_L;  nres = K_2L;  a_off = '0;
        a_rd = acc_rd;  b_rd = base_rd; r_rd = prod_rd;
      end
    endcase
  end

  assign a_addr   = a_off + i_q;
  assign r_addr   = i_q + j_q;
  assign c_addr   = i_q + nb;
  // modulus widened by one zero limb at the top
  assign mod_w    = (k_q == K_L) ? '0 : mod_rd;
  assign ebit_now = exp_rd[bit_q[4:0]];

  always_comb begin
    state_d = state_q;  mul_d = mul_q;
    i_d = i_q;  j_d = j_q;  k_d = k_q;  bit_d = bit_q;  trial_d = trial_q;
    carry_d = carry_q;  a_d = a_q;  borrow_d = borrow_q;
    ebit_d = ebit_q;  started_d = started_q;  sq_d = sq_q;
    out_valid_d = out_valid_q;  out_last_d = out_last_q;
    out_idx_d = out_idx_q;  out_limb_d = out_limb_q;

    base_re = 1'b0; exp_re = 1'b0; mod_re = 1'b0; mu_re = 1'b0; acc_re = 1'b0;
    prod_re = 1'b0; quot_re = 1'b0; back_re = 1'b0; low_re = 1'b0;
    base_ra = j_q;  exp_ra = CW'(bit_q[BW-1:5]);  mod_ra = j_q;  mu_ra = j_q;
    acc_ra = j_q;   prod_ra = r_addr;  quot_ra = r_addr;  back_ra = r_addr;
    low_ra = k_q;
    acc_we = 1'b0;  acc_wa = k_q;  acc_wd = '0;
    res_we = 1'b0;  res_wa = r_addr;  res_wd = alu_rsp.lo;
    low_we = 1'b0;  low_wa = k_q;  low_wd = alu_rsp.lo;

    alu_req.op  = ALU_MAC;
    alu_req.a   = a_q;
    alu_req.b   = b_rd;
    alu_req.c   = (i_q == '0) ? '0 : r_rd;
    alu_req.cin = carry_q;

    // drain the output register when taken
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_op == OP_COMPUTE)) begin
          k_d = '0;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        // accumulator = 1
        acc_we = 1'b1;
        acc_wd = (k_q == '0) ? LW'(1) : '0;
        started_d = 1'b0;
        k_d = k_q + CW'(1);
        if (k_q == K_LM1) begin
          bit_d = BIT_TOP;
          state_d = S_EXPRD;
        end
      end
      S_EXPRD: begin
        exp_re = 1'b1;
        state_d = S_EXPBIT;
      end
      S_EXPBIT: begin
        ebit_d = ebit_now;
        if (started_q || ebit_now) begin
          sq_d = started_q;
          started_d = 1'b1;
          mul_d = MUL_PROD;
          i_d = '0;
          state_d = S_ROWA;
        end else if (bit_q == '0) begin
          k_d = '0;
          state_d = S_OUTRD;
        end else begin
          bit_d = bit_q - BW'(1);
          state_d = S_EXPRD;
        end
      end
      S_ROWA: begin
        // fetch the row multiplier limb
        case (mul_q)
          MUL_PROD: begin acc_re = 1'b1;  acc_ra = a_addr; end
          MUL_QUOT: begin prod_re = 1'b1; prod_ra = a_addr; end
          MUL_BACK: begin quot_re = 1'b1; quot_ra = a_addr; end
          default: ;
        endcase
        state_d = S_ROWB;
      end
      S_ROWB: begin
        a_d = a_rd;
        j_d = '0;
        carry_d = '0;
        state_d = S_RD;
      end
      S_RD: begin
        case (mul_q)
          MUL_PROD: begin
            acc_re = sq_q;  base_re = !sq_q;  prod_re = 1'b1;
          end
          MUL_QUOT: begin mu_re = 1'b1;  quot_re = 1'b1; end
          MUL_BACK: begin mod_re = 1'b1; back_re = 1'b1; end
          default: ;
        endcase
        state_d = S_MAC;
      end
      S_MAC: begin
        res_we = 1'b1;
        carry_d = alu_rsp.hi;
        if (((j_q + CW'(1)) < nb) && ((r_addr + CW'(1)) < nres)) begin
          j_d = j_q + CW'(1);
          state_d = S_RD;
        end else if (((j_q + CW'(1)) == nb) && (c_addr < nres)) begin
          state_d = S_CARRY;
        end else if ((i_q + CW'(1)) < na) begin
          i_d = i_q + CW'(1);
          state_d = S_ROWA;
        end else begin
          i_d = '0;
          case (mul_q)
            MUL_PROD: begin mul_d = MUL_QUOT; state_d = S_ROWA; end
            MUL_QUOT: begin mul_d = MUL_BACK; state_d = S_ROWA; end
            default: begin k_d = '0; borrow_d = 1'b0; state_d = S_SUBRD; end
          endcase
        end
      end
      S_CARRY: begin
        // top limb of the row takes the final carry
        res_we = 1'b1;
        res_wa = c_addr;
        res_wd = carry_q;
        if ((i_q + CW'(1)) < na) begin
          i_d = i_q + CW'(1);
          state_d = S_ROWA;
        end else begin
          i_d = '0;
          case (mul_q)
            MUL_PROD: begin mul_d = MUL_QUOT; state_d = S_ROWA; end
            MUL_QUOT: begin mul_d = MUL_BACK; state_d = S_ROWA; end
            default: begin k_d = '0; borrow_d = 1'b0; state_d = S_SUBRD; end
          endcase
        end
      end
      S_SUBRD: begin
        prod_re = 1'b1;  prod_ra = k_q;
        back_re = 1'b1;  back_ra = k_q;
        state_d = S_SUBWR;
      end
      S_SUBWR: begin
        // low = x - r2 over LIMBS+1 limbs, wrapping
        alu_req.op  = ALU_SUB;
        alu_req.a   = prod_rd;
        alu_req.b   = back_rd;
        alu_req.cin = {{(LW-1){1'b0}}, borrow_q};
        low_we = 1'b1;
        borrow_d = alu_rsp.hi[0];
        if (k_q == K_L) begin
          trial_d = '0;
          state_d = S_CMPRD;
        end else begin
          k_d = k_q + CW'(1);
          state_d = S_SUBRD;
        end
      end
      S_CMPRD: begin
        low_re = 1'b1;
        mod_re = 1'b1;  mod_ra = k_q;
        state_d = S_CMPCHK;
      end
      S_CMPCHK: begin
        // scan from the top limb down until the limbs differ
        if ((low_rd != mod_w) || (k_q == '0)) begin
          if ((low_rd >= mod_w)) begin
            k_d = '0;
            borrow_d = 1'b0;
            state_d = S_TSUBRD;
          end else begin
            k_d = '0;
            state_d = S_COPYRD;
          end
        end else begin
          k_d = k_q - CW'(1);
          state_d = S_CMPRD;
        end
      end
      S_TSUBRD: begin
        low_re = 1'b1;
        mod_re = 1'b1;  mod_ra = k_q;
        state_d = S_TSUBWR;
      end
      S_TSUBWR: begin
        alu_req.op  = ALU_SUB;
        alu_req.a   = low_rd;
        alu_req.b   = mod_w;
        alu_req.cin = {{(LW-1){1'b0}}, borrow_q};
        low_we = 1'b1;
        borrow_d = alu_rsp.hi[0];
        if (k_q == K_L) begin
          trial_d = trial_q + 2'd1;
          if (trial_q == 2'd2) begin
            k_d = '0;
            state_d = S_COPYRD;
          end else begin
            k_d = K_L;
            state_d = S_CMPRD;
          end
        end else begin
          k_d = k_q + CW'(1);
          state_d = S_TSUBRD;
        end
      end
      S_COPYRD: begin
        low_re = 1'b1;
        state_d = S_COPYWR;
      end
      S_COPYWR: begin
        acc_we = 1'b1;
        acc_wd = low_rd;
        if (k_q == K_LM1) begin
          if (sq_q && ebit_q) begin
            // square done; now the multiply by base for this bit
            sq_d = 1'b0;
            mul_d = MUL_PROD;
            i_d = '0;
            state_d = S_ROWA;
          end else if (bit_q == '0) begin
            k_d = '0;
            state_d = S_OUTRD;
          end else begin
            bit_d = bit_q - BW'(1);
            state_d = S_EXPRD;
          end
        end else begin
          k_d = k_q + CW'(1);
          state_d = S_COPYRD;
        end
      end
      S_OUTRD: begin
        acc_re = 1'b1;  acc_ra = k_q;
        state_d = S_OUTLD;
      end
      S_OUTLD: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_idx_d   = RIDX_W'(k_q);
          out_limb_d  = acc_rd;
          out_last_d  = (k_q == K_LM1);
          if (k_q == K_LM1) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q + CW'(1);
            state_d = S_OUTRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mul_q       <= MUL_PROD;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      bit_q       <= '0;
      trial_q     <= '0;
      ebit_q      <= 1'b0;
      started_q   <= 1'b0;
      sq_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mul_q       <= mul_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      bit_q       <= bit_d;
      trial_q     <= trial_d;
      ebit_q      <= ebit_d;
      started_q   <= started_d;
      sq_q        <= sq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q    <= carry_d;
    a_q        <= a_d;
    borrow_q   <= borrow_d;
    out_idx_q  <= out_idx_d;
    out_limb_q <= out_limb_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DW-RIDX_W-LW){1'b0}}, out_limb_q, out_idx_q};
  assign m_axis_tlast_o  = out_last_q;

  bme_ram #(.WIDTH(LW), .DEPTH(LIMBS)) u_base (
    .clk_i, .we_i(base_we), .waddr_i(load_idx[$clog2(LIMBS)-1:0]), .wdata_i(load_val),
    .re_i(base_re), .raddr_i(base_ra[$clog2(LIMBS)-1:0]), .rdata_o(base_rd));
  bme_ram #(.WIDTH(LW), .DEPTH(LIMBS)) u_exp (
    .clk_i, .we_i(exp_we), .waddr_i(load_idx[$clog2(LIMBS)-1:0]), .wdata_i(load_val),
    .re_i(exp_re), .raddr_i(exp_ra[$clog2(LIMBS)-1:0]), .rdata_o(exp_rd));
  bme_ram #(.WIDTH(LW), .DEPTH(LIMBS)) u_mod (
    .clk_i, .we_i(mod_we), .waddr_i(load_idx[$clog2(LIMBS)-1:0]), .wdata_i(load_val),
    .re_i(mod_re), .raddr_i(mod_ra[$clog2(LIMBS)-1:0]), .rdata_o(mod_rd));
  bme_ram #(.WIDTH(LW), .DEPTH(LIMBS + 1)) u_mu (
    .clk_i, .we_i(mu_we), .waddr_i(load_idx[$clog2(LIMBS+1)-1:0]), .wdata_i(load_val),
    .re_i(mu_re), .raddr_i(mu_ra[$clog2(LIMBS+1)-1:0]), .rdata_o(mu_rd));
  bme_ram #(.WIDTH(LW), .DEPTH(LIMBS)) u_acc (
    .clk_i, .we_i(acc_we), .waddr_i(acc_wa[$clog2(LIMBS)-1:0]), .wdata_i(acc_wd),
    .re_i(acc_re), .raddr_i(acc_ra[$clog2(LIMBS)-1:0]), .rdata_o(acc_rd));
  bme_ram #(.WIDTH(LW), .DEPTH(2 * LIMBS)) u_prod (
    .clk_i, .we_i(prod_we), .waddr_i(res_wa[$clog2(2*LIMBS)-1:0]), .wdata_i(res_wd),
    .re_i(prod_re), .raddr_i(prod_ra[$clog2(2*LIMBS)-1:0]), .rdata_o(prod_rd));
  bme_ram #(.WIDTH(LW), .DEPTH(2 * LIMBS + 2)) u_quot (
    .clk_i, .we_i(quot_we), .waddr_i(res_wa[$clog2(2*LIMBS+2)-1:0]), .wdata_i(res_wd),
    .re_i(quot_re), .raddr_i(quot_ra[$clog2(2*LIMBS+2)-1:0]), .rdata_o(quot_rd));
  bme_ram #(.WIDTH(LW), .DEPTH(LIMBS + 1)) u_back (
    .clk_i, .we_i(back_we), .waddr_i(res_wa[$clog2(LIMBS+1)-1:0]), .wdata_i(res_wd),
    .re_i(back_re), .raddr_i(back_ra[$clog2(LIMBS+1)-1:0]), .rdata_o(back_rd));
  bme_ram #(.WIDTH(LW), .DEPTH(LIMBS + 1)) u_low (
    .clk_i, .we_i(low_we), .waddr_i(low_wa[$clog2(LIMBS+1)-1:0]), .wdata_i(low_wd),
    .re_i(low_re), .raddr_i(low_ra[$clog2(LIMBS+1)-1:0]), .rdata_o(low_rd));

  `BME_ASSERT_IMP(a_mac_in_range, state_q == S_MAC, r_addr < nres, "product limb beyond buffer")
  `BME_ASSERT_IMP(a_carry_in_range, state_q == S_CARRY, c_addr < nres, "carry limb beyond buffer")
  `BME_ASSERT_IMP(a_trial_bound, state_q == S_TSUBWR, trial_q != 2'd3, "fourth trial subtract")
  `BME_ASSERT_IMP(a_last_index, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tdata_o[5:0] == RIDX_W'(K_LM1), "last flag off the top limb")
  `BME_ASSERT_NXT(a_compute_starts, state_q == S_IDLE && s_axis_tvalid_i && s_axis_tuser_i == OP_COMPUTE, state_q == S_INIT, "compute item not started")

endmodule
